/* hdl/lla_pkg.sv */
// ----------------------------------------------------------------------------
// lla_pkg
// shared types and codes for the life-like automaton step block
// ----------------------------------------------------------------------------
package lla_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_BIRTH   = 2'd2,
    CFG_SURVIVE = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DONE
  } state_t;

  // broadcast from the sequencer to every row cell
  typedef struct packed {
    logic write_en;
    logic clear;
    logic advance;
    logic rotate;
  } row_ctrl_t;

endpackage

/* hdl/life_like_automaton_step.sv */
// ----------------------------------------------------------------------------
// life_like_automaton_step
// toroidal life-like automaton: write, read, clear or advance the grid
//
// Input channel carries one word per command (mode, cell_x, cell_y,
// cell_value), accepted when in_valid is high and in_stall low. Each word
// gives exactly one result word on the out channel.
// The grid is a ring of MAX_HEIGHT row cells. An advance rotates the ring
// one row per cycle, each active row computing its next value from its
// neighbors as it passes the top: the result is registered once ST_STEP
// and ST_DONE have run. Write, read and clear go through ST_DONE alone.
// One command is worked on at a time; the result register holds while
// out_stall is high and a new word is taken the cycle after it is delivered.
// Reset (rst_n low, synchronous) kills every cell and loads the registers
// with 64, 64, B3, S23. The cfg port (cfg_valid/cfg_ready) is always ready.
// ----------------------------------------------------------------------------
module life_like_automaton_step
  import lla_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [5:0] in_cell_x,
  input  logic [5:0] in_cell_y,
  input  logic       in_cell_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_cell_alive,
  output logic [1:0] out_done_mode,
  output logic       out_coord_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int W   = MAX_WIDTH;
  localparam int H   = MAX_HEIGHT;
  localparam int XW  = $clog2(W);
  localparam int YW  = $clog2(H);
  localparam int CW  = $clog2(W + 1) > 7 ? $clog2(W + 1) : 7;
  localparam int RW  = $clog2(H + 1) > 7 ? $clog2(H + 1) : 7;

  logic [6:0] gw_r, gh_r;
  logic [8:0] birth_r, surv_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r    <= 7'd64;
      gh_r    <= 7'd64;
      birth_r <= 9'd8;
      surv_r  <= 9'd12;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:   gw_r    <= cfg_data[6:0];
        CFG_HEIGHT:  gh_r    <= cfg_data[6:0];
        CFG_BIRTH:   birth_r <= cfg_data;
        CFG_SURVIVE: surv_r  <= cfg_data;
      endcase
    end
  end

  // working sizes saturated into [3, max]
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  always_comb begin
    if (gw_r < 7'd3) w_eff = CW'(3);
    else if (CW'(gw_r) > CW'(W)) w_eff = CW'(W);
    else w_eff = CW'(gw_r);
    if (gh_r < 7'd3) h_eff = RW'(3);
    else if (RW'(gh_r) > RW'(H)) h_eff = RW'(H);
    else h_eff = RW'(gh_r);
  end

  // command registers
  state_t        st_r, st_nxt;
  logic [1:0]    mode_r;
  logic [5:0]    cx_r, cy_r;
  logic          cv_r;
  logic [RW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, alive_r, err_r;

  logic          accept;
  logic          in_area;
  row_ctrl_t     ctrl;
  logic [W-1:0]  rows_q [H];
  logic [W-1:0]  rule_nxt;
  logic [W-1:0]  wmask;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE) || out_valid_r;
  assign in_area  = (CW'(cx_r) < w_eff) && (RW'(cy_r) < h_eff);

  always_comb begin
    wmask = '0;
    wmask[cx_r[XW-1:0]] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      cx_r   <= in_cell_x;
      cy_r   <= in_cell_y;
      cv_r   <= in_cell_value;
    end
  end

  // ring position 0 is the row being updated; the row before it has already
  // been advanced, so its old value is kept in old_mid_r
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    ctrl    = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          st_nxt  = (mode_t'(in_mode) == MODE_ADVANCE) ? ST_STEP : ST_DONE;
        end
      end
      ST_STEP: begin
        ctrl.rotate = 1'b1;
        ctrl.advance = (cnt_r < h_eff);
        cnt_nxt = RW'(cnt_r + 1'b1);
        if (cnt_r == RW'(H - 1)) st_nxt = ST_DONE;
      end
      ST_DONE: begin
        ctrl.write_en = (mode_t'(mode_r) == MODE_WRITE) && in_area;
        ctrl.clear    = (mode_t'(mode_r) == MODE_CLEAR);
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (st_r == ST_DONE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_DONE) begin
      alive_r <= (mode_t'(mode_r) == MODE_READ) && in_area
                 && rows_q[cy_r[YW-1:0]][cx_r[XW-1:0]];
      err_r   <= ((mode_t'(mode_r) == MODE_WRITE) || (mode_t'(mode_r) == MODE_READ))
                 && !in_area;
    end
  end

  // upper neighbor of row 0: at the first step the old active last row;
  // later the old copy of the row that just left position 0
  logic [W-1:0] up_row, dn_row, first_row_r, old_mid_r;
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && accept) first_row_r <= rows_q[0];
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_STEP) old_mid_r <= rows_q[0];
  end

  always_comb begin
    up_row = (cnt_r == '0) ? rows_q[h_eff[YW-1:0] - YW'(1)] : old_mid_r;
    // lower neighbor: last active row wraps to old row 0
    dn_row = (cnt_r == RW'(h_eff - 1'b1)) ? first_row_r : rows_q[1 % H];
  end

  lla_rule #(.W(W), .CW(CW)) u_rule (
    .up      (up_row),
    .mid     (rows_q[0]),
    .dn      (dn_row),
    .width   (w_eff),
    .birth   (birth_r),
    .survive (surv_r),
    .nxt     (rule_nxt)
  );

  for (genvar r = 0; r < H; r++) begin : g_row
    logic [W-1:0] nin;
    // a row moving from position 0 to H-1 carries its next value
    assign nin = (r == H - 1) ? rule_nxt : rows_q[(r + 1) % H];
    lla_row #(.W(W)) u_row (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .sel     (cy_r[YW-1:0] == YW'(r)),
      .wmask   (wmask),
      .wval    (cv_r),
      .next_in (nin),
      .rot_in  ((r == H - 1) ? rows_q[0] : rows_q[(r + 1) % H]),
      .row_q   (rows_q[r])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_cell_alive  = alive_r;
  assign out_done_mode   = mode_r;
  assign out_coord_error = err_r;

endmodule

/* hdl/lla_row.sv */
// ----------------------------------------------------------------------------
// lla_row
// one row of the grid; rows form a ring that rotates one row a cycle
// ----------------------------------------------------------------------------
module lla_row
  import lla_pkg::*;
#(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  row_ctrl_t      ctrl,
  input  logic           sel,
  input  logic [W-1:0]   wmask,
  input  logic           wval,
  input  logic [W-1:0]   next_in,
  input  logic [W-1:0]   rot_in,
  output logic [W-1:0]   row_q
);

  logic [W-1:0] row_r, row_nxt;

  always_comb begin
    row_nxt = row_r;
    priority if (ctrl.clear) begin
      row_nxt = '0;
    end else if (ctrl.write_en && sel) begin
      row_nxt = (row_r & ~wmask) | (wval ? wmask : '0);
    end else if (ctrl.advance) begin
      row_nxt = next_in;
    end else if (ctrl.rotate) begin
      row_nxt = rot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule

/* hdl/lla_rule.sv */
// ----------------------------------------------------------------------------
// lla_rule
// next value of one row from itself and the rows above and below, with column wrap
// ----------------------------------------------------------------------------
module lla_rule
  import lla_pkg::*;
#(
  parameter int W  = 64,
  parameter int CW = 7
) (
  input  logic [W-1:0]  up,
  input  logic [W-1:0]  mid,
  input  logic [W-1:0]  dn,
  input  logic [CW-1:0] width,
  input  logic [8:0]    birth,
  input  logic [8:0]    survive,
  output logic [W-1:0]  nxt
);

  always_comb begin
    for (int x = 0; x < W; x++) begin
      logic [CW-1:0] lf, rt;
      logic [3:0] n;
      lf = (x == 0) ? CW'(width - 1'b1) : CW'(x - 1);
      rt = (CW'(x + 1) == width) ? '0 : CW'(x + 1);
      n = 4'(up[lf[$clog2(W)-1:0]]) + 4'(up[x]) + 4'(up[rt[$clog2(W)-1:0]])
        + 4'(mid[lf[$clog2(W)-1:0]]) + 4'(mid[rt[$clog2(W)-1:0]])
        + 4'(dn[lf[$clog2(W)-1:0]]) + 4'(dn[x]) + 4'(dn[rt[$clog2(W)-1:0]]);
      if (CW'(x) < width) begin
        nxt[x] = mid[x] ? survive[n] : birth[n];
      end else begin
        nxt[x] = mid[x];
      end
    end
  end

endmodule
